>>> design/mesh_volume_and_area_macros.svh
// assertion macros for the file that checks itself
`ifndef MESH_VOLUME_AND_AREA_MACROS_SVH
`define MESH_VOLUME_AND_AREA_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define MVA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// next-cycle implication
`define MVA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MVA_ASSERT_IMP(label, clk, rstn, ante, cons)
`define MVA_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> design/mva_pkg.sv
package mva_pkg;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic               last_triangle;
    } in_word_t;

    typedef struct packed {
        logic signed [63:0] total_volume;
        logic        [62:0] total_area;
        logic               saturated;
    } out_word_t;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_REF_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_REF_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REF_Z = 2'd2;

    // positions of the difference vectors in a queue word, in coordinate slots
    localparam int F_AB = 0;
    localparam int F_AC = 3;
    localparam int F_XA = 6;

    localparam int QUEUE_DEPTH = 2;

    // 2^34 / 3 rounded up, exact quotient for dividends below 2^33
    localparam logic [32:0] RECIP3 = 33'h1_5555_5556;
    // floor(2^32 / 3)
    localparam logic [31:0] THIRD_WORD = 32'h5555_5555;
    localparam logic [63:0] VOL_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] VOL_MIN = 64'h8000_0000_0000_0000;
    localparam logic [62:0] AREA_MAX = 63'h7fff_ffff_ffff_ffff;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_ACC,
        BK_PREP,
        BK_ROOT,
        BK_FIN
    } back_state_t;

    typedef enum logic [1:0] {
        PH_CROSS,
        PH_DOT,
        PH_SQ
    } phase_t;

    function automatic logic [1:0] next3(input logic [1:0] i);
        next3 = (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

endpackage

>>> design/mva_front.sv
module mva_front #(
    parameter int COORD_WIDTH = 32,
    localparam int D = COORD_WIDTH + 1,
    localparam int ENTRY_W = 9 * D + 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mva_pkg::in_word_t   s_data,
    input  logic [31:0]         ref_x,
    input  logic [31:0]         ref_y,
    input  logic [31:0]         ref_z,
    output logic                f_valid,
    output logic [ENTRY_W-1:0]  f_entry,
    input  logic                q_ready
);

    logic               f_valid_reg, f_valid_next;
    logic [ENTRY_W-1:0] f_entry_reg, entry_next;
    logic signed [D-1:0] va [3];
    logic signed [D-1:0] vb [3];
    logic signed [D-1:0] vc [3];
    logic signed [D-1:0] vr [3];
    logic               take;

    assign s_ready = !f_valid_reg || q_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        va[0] = D'($signed(s_data.ax[COORD_WIDTH-1:0]));
        va[1] = D'($signed(s_data.ay[COORD_WIDTH-1:0]));
        va[2] = D'($signed(s_data.az[COORD_WIDTH-1:0]));
        vb[0] = D'($signed(s_data.bx[COORD_WIDTH-1:0]));
        vb[1] = D'($signed(s_data.by[COORD_WIDTH-1:0]));
        vb[2] = D'($signed(s_data.bz[COORD_WIDTH-1:0]));
        vc[0] = D'($signed(s_data.cx[COORD_WIDTH-1:0]));
        vc[1] = D'($signed(s_data.cy[COORD_WIDTH-1:0]));
        vc[2] = D'($signed(s_data.cz[COORD_WIDTH-1:0]));
        vr[0] = D'($signed(ref_x[COORD_WIDTH-1:0]));
        vr[1] = D'($signed(ref_y[COORD_WIDTH-1:0]));
        vr[2] = D'($signed(ref_z[COORD_WIDTH-1:0]));
        entry_next = '0;
        entry_next[0] = s_data.last_triangle;
        for (int i = 0; i < 3; i++) begin
            entry_next[1 + (mva_pkg::F_AB + i) * D +: D] = vb[i] - va[i];
            entry_next[1 + (mva_pkg::F_AC + i) * D +: D] = vc[i] - va[i];
            entry_next[1 + (mva_pkg::F_XA + i) * D +: D] = va[i] - vr[i];
        end
        f_valid_next = take ? 1'b1 : (f_valid_reg && !q_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f_entry_reg <= entry_next;
        end
    end

    assign f_valid = f_valid_reg;
    assign f_entry = f_entry_reg;

endmodule

>>> design/mva_fifo.sv
module mva_fifo #(
    parameter int WIDTH = 298
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (mva_pkg::QUEUE_DEPTH > 1) ? $clog2(mva_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(mva_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [mva_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CW'(mva_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        bump = (p == PW'(mva_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> design/mva_back.sv
module mva_back #(
    parameter int COORD_WIDTH = 32,
    localparam int D = COORD_WIDTH + 1,
    localparam int ENTRY_W = 9 * D + 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_ready,
    input  logic [ENTRY_W-1:0] q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mva_pkg::out_word_t m_data
);

    localparam int MW = D + 1;
    localparam int NW = 2 * D + 1;
    localparam int DW = 3 * COORD_WIDTH + 6;
    localparam int SW = 2 * NW + 2;
    localparam int MGW = DW + 1;
    localparam int NCH = (MGW + 30) / 32;
    localparam int XW = 32 * NCH;
    localparam int LOOP_N = (NCH > NW) ? NCH : NW;
    localparam int CNT_W = $clog2(LOOP_N + 1);
    localparam int RW = NW + 2;
    localparam int VSW = ((XW > 64) ? XW : 64) + 2;
    localparam int ASW = ((NW > 63) ? NW : 63) + 1;

    mva_pkg::back_state_t state_reg, state_next;
    mva_pkg::phase_t      phase_reg, phase_next;
    logic [1:0]           comp_reg, comp_next;
    logic [1:0]           part_reg, part_next;
    logic [ENTRY_W-1:0]   ent_reg, ent_next;
    logic signed [NW-1:0] n_reg [3];
    logic signed [NW-1:0] n_next [3];
    logic signed [DW-1:0] dot_reg, dot_next;
    logic signed [SW-1:0] sq_reg, sq_next;
    logic signed [2*MW-1:0] prod_reg, prod_next;
    logic                 neg_reg, neg_next;
    logic [XW-1:0]        dsh_reg, dsh_next;
    logic [1:0]           drem_reg, drem_next;
    logic [2*NW-1:0]      sqv_reg, sqv_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [NW-1:0]        root_reg, root_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic signed [63:0]   vol_acc_reg, vol_acc_next;
    logic [62:0]          area_acc_reg, area_acc_next;
    logic                 ovf_reg, ovf_next;
    logic                 m_valid_reg, m_valid_next;
    mva_pkg::out_word_t   m_data_reg, m_data_next;

    logic signed [D-1:0]  ab [3];
    logic signed [D-1:0]  ac [3];
    logic signed [D-1:0]  xa [3];
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [MW-1:0] n_lo, n_hi;
    logic [1:0]           i1, i2;
    logic [DW-1:0]        mag_abs;
    logic [MGW-1:0]       mag;
    logic [31:0]          d_word;
    logic [32:0]          d_num;
    logic [65:0]          d_prod;
    logic [31:0]          d_quo;
    logic [31:0]          d_base;
    logic [1:0]           d_rem;
    logic [RW+1:0]        rs, trial;
    logic signed [VSW-1:0] qv, vterm, vsum;
    logic                 vfits;
    logic [ASW-1:0]       asum;
    logic                 a_ovf;
    logic signed [63:0]   vol_new;
    logic [62:0]          area_new;
    logic                 out_free;
    logic                 last_done;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ab[i] = $signed(ent_reg[1 + (mva_pkg::F_AB + i) * D +: D]);
            ac[i] = $signed(ent_reg[1 + (mva_pkg::F_AC + i) * D +: D]);
            xa[i] = $signed(ent_reg[1 + (mva_pkg::F_XA + i) * D +: D]);
        end
    end

    // n = hi * 2^D + lo with lo unsigned
    assign n_lo = $signed({1'b0, n_reg[comp_reg][D-1:0]});
    assign n_hi = $signed(n_reg[comp_reg][NW-1:D]);
    assign i1   = mva_pkg::next3(comp_reg);
    assign i2   = mva_pkg::next3(i1);

    always_comb begin
        mul_a = MW'(ab[i1]);
        mul_b = MW'(ac[i2]);
        case (phase_reg)
            mva_pkg::PH_CROSS: begin
                mul_a = (part_reg == 2'd0) ? MW'(ab[i1]) : MW'(ac[i1]);
                mul_b = (part_reg == 2'd0) ? MW'(ac[i2]) : MW'(ab[i2]);
            end
            mva_pkg::PH_DOT: begin
                mul_a = MW'(xa[comp_reg]);
                mul_b = (part_reg == 2'd0) ? n_lo : n_hi;
            end
            mva_pkg::PH_SQ: begin
                mul_a = (part_reg == 2'd0) ? n_lo : n_hi;
                mul_b = (part_reg == 2'd2) ? n_hi : n_lo;
            end
            default: begin
                mul_a = MW'(ab[i1]);
                mul_b = MW'(ac[i2]);
            end
        endcase
    end

    // halved magnitude divided by three, one 32-bit chunk a cycle from the top
    // 2^32 leaves remainder one mod three, so the carried remainder adds in
    always_comb begin
        d_word = dsh_reg[XW-1 -: 32];
        d_num  = 33'(d_word) + 33'(drem_reg);
        d_prod = 66'(d_num) * 66'(mva_pkg::RECIP3);
        d_quo  = d_prod[65:34];
        d_base = drem_reg[1] ? (mva_pkg::THIRD_WORD << 1)
                             : (drem_reg[0] ? mva_pkg::THIRD_WORD : '0);
        d_rem  = 2'(d_num - {d_quo, 1'b0} - 33'(d_quo));
    end

    // square root, one result bit a cycle
    assign rs    = {rem_reg, sqv_reg[2*NW-1:2*NW-2]};
    assign trial = (RW + 2)'({root_reg, 2'b01});

    assign mag_abs = dot_reg[DW-1] ? DW'(-dot_reg) : DW'(dot_reg);
    assign mag     = MGW'(mag_abs) + MGW'(3);

    always_comb begin
        qv    = $signed({{(VSW - XW){1'b0}}, dsh_reg});
        vterm = neg_reg ? -qv : qv;
        vsum  = VSW'(vol_acc_reg) + vterm;
        vfits = (&vsum[VSW-1:63]) || !(|vsum[VSW-1:63]);
        vol_new = vfits ? vsum[63:0] : (vsum[VSW-1] ? mva_pkg::VOL_MIN : mva_pkg::VOL_MAX);
        asum  = ASW'(area_acc_reg) + ASW'(root_reg);
        a_ovf = |asum[ASW-1:63];
        area_new = a_ovf ? mva_pkg::AREA_MAX : asum[62:0];
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign last_done = ent_reg[0];

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        comp_next     = comp_reg;
        part_next     = part_reg;
        ent_next      = ent_reg;
        n_next        = n_reg;
        dot_next      = dot_reg;
        sq_next       = sq_reg;
        prod_next     = prod_reg;
        neg_next      = neg_reg;
        dsh_next      = dsh_reg;
        drem_next     = drem_reg;
        sqv_next      = sqv_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        cnt_next      = cnt_reg;
        vol_acc_next  = vol_acc_reg;
        area_acc_next = area_acc_reg;
        ovf_next      = ovf_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        q_ready       = 1'b0;
        case (state_reg)
            mva_pkg::BK_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    ent_next   = q_data;
                    for (int i = 0; i < 3; i++) begin
                        n_next[i] = '0;
                    end
                    dot_next   = '0;
                    sq_next    = '0;
                    phase_next = mva_pkg::PH_CROSS;
                    comp_next  = 2'd0;
                    part_next  = 2'd0;
                    state_next = mva_pkg::BK_MUL;
                end
            end
            mva_pkg::BK_MUL: begin
                prod_next  = mul_a * mul_b;
                state_next = mva_pkg::BK_ACC;
            end
            mva_pkg::BK_ACC: begin
                state_next = mva_pkg::BK_MUL;
                case (phase_reg)
                    mva_pkg::PH_CROSS: begin
                        if (part_reg == 2'd0) begin
                            n_next[comp_reg] = n_reg[comp_reg] + NW'(prod_reg);
                            part_next = 2'd1;
                        end else begin
                            n_next[comp_reg] = n_reg[comp_reg] - NW'(prod_reg);
                            part_next = 2'd0;
                            if (comp_reg == 2'd2) begin
                                comp_next  = 2'd0;
                                phase_next = mva_pkg::PH_DOT;
                            end else begin
                                comp_next = comp_reg + 2'd1;
                            end
                        end
                    end
                    mva_pkg::PH_DOT: begin
                        if (part_reg == 2'd0) begin
                            dot_next  = dot_reg + DW'(prod_reg);
                            part_next = 2'd1;
                        end else begin
                            dot_next  = dot_reg + (DW'(prod_reg) <<< D);
                            part_next = 2'd0;
                            if (comp_reg == 2'd2) begin
                                comp_next  = 2'd0;
                                phase_next = mva_pkg::PH_SQ;
                            end else begin
                                comp_next = comp_reg + 2'd1;
                            end
                        end
                    end
                    mva_pkg::PH_SQ: begin
                        if (part_reg == 2'd0) begin
                            sq_next   = sq_reg + SW'(prod_reg);
                            part_next = 2'd1;
                        end else if (part_reg == 2'd1) begin
                            // cross term counted twice
                            sq_next   = sq_reg + (SW'(prod_reg) <<< (D + 1));
                            part_next = 2'd2;
                        end else begin
                            sq_next   = sq_reg + (SW'(prod_reg) <<< (2 * D));
                            part_next = 2'd0;
                            if (comp_reg == 2'd2) begin
                                comp_next  = 2'd0;
                                state_next = mva_pkg::BK_PREP;
                            end else begin
                                comp_next = comp_reg + 2'd1;
                            end
                        end
                    end
                    default: begin
                        state_next = mva_pkg::BK_IDLE;
                    end
                endcase
            end
            mva_pkg::BK_PREP: begin
                neg_next   = dot_reg[DW-1];
                dsh_next   = XW'(mag[MGW-1:1]);
                drem_next  = '0;
                sqv_next   = sq_reg[SW-1:2];
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = mva_pkg::BK_ROOT;
            end
            mva_pkg::BK_ROOT: begin
                if (cnt_reg < CNT_W'(NCH)) begin
                    dsh_next  = {dsh_reg[XW-33:0], d_base + d_quo};
                    drem_next = d_rem;
                end
                if (cnt_reg < CNT_W'(NW)) begin
                    sqv_next = sqv_reg << 2;
                    if (rs >= trial) begin
                        rem_next  = RW'(rs - trial);
                        root_next = {root_reg[NW-2:0], 1'b1};
                    end else begin
                        rem_next  = RW'(rs);
                        root_next = {root_reg[NW-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LOOP_N - 1)) begin
                    state_next = mva_pkg::BK_FIN;
                end
            end
            mva_pkg::BK_FIN: begin
                if (!last_done) begin
                    vol_acc_next  = vol_new;
                    area_acc_next = area_new;
                    ovf_next      = ovf_reg || !vfits || a_ovf;
                    state_next    = mva_pkg::BK_IDLE;
                end else if (out_free) begin
                    m_data_next.total_volume = vol_new;
                    m_data_next.total_area   = area_new;
                    m_data_next.saturated    = ovf_reg || !vfits || a_ovf;
                    m_valid_next  = 1'b1;
                    vol_acc_next  = '0;
                    area_acc_next = '0;
                    ovf_next      = 1'b0;
                    state_next    = mva_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = mva_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mva_pkg::BK_IDLE;
            phase_reg    <= mva_pkg::PH_CROSS;
            comp_reg     <= '0;
            part_reg     <= '0;
            cnt_reg      <= '0;
            vol_acc_reg  <= '0;
            area_acc_reg <= '0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            comp_reg     <= comp_next;
            part_reg     <= part_next;
            cnt_reg      <= cnt_next;
            vol_acc_reg  <= vol_acc_next;
            area_acc_reg <= area_acc_next;
            ovf_reg      <= ovf_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg    <= ent_next;
        n_reg      <= n_next;
        dot_reg    <= dot_next;
        sq_reg     <= sq_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        dsh_reg    <= dsh_next;
        drem_reg   <= drem_next;
        sqv_reg    <= sqv_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> design/mesh_volume_and_area.sv
// triangle mesh volume and area: one triangle per word, totals on the last word
// the back handles one triangle at a time, in 21 steps of the shared multiplier
//   followed by the bit-a-cycle square root
// a two-word queue lets the front take new triangles while the back works
// reset: synchronous active-low aresetn clears control, totals and ref point to 0
`include "mesh_volume_and_area_macros.svh"

module mesh_volume_and_area #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mva_pkg::in_word_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mva_pkg::out_word_t                m_data,
    input  logic                              cfg_we,
    input  logic [mva_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mva_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int D = COORD_WIDTH + 1;
    localparam int ENTRY_W = 9 * D + 1;

    logic [31:0]        ref_x_reg, ref_y_reg, ref_z_reg;
    logic               f_valid;
    logic [ENTRY_W-1:0] f_entry;
    logic               q_in_ready;
    logic               q_out_valid;
    logic               q_out_ready;
    logic [ENTRY_W-1:0] q_out_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_z_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                mva_pkg::CFG_REF_X: ref_x_reg <= cfg_wdata;
                mva_pkg::CFG_REF_Y: ref_y_reg <= cfg_wdata;
                mva_pkg::CFG_REF_Z: ref_z_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    mva_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .ref_x   (ref_x_reg),
        .ref_y   (ref_y_reg),
        .ref_z   (ref_z_reg),
        .f_valid (f_valid),
        .f_entry (f_entry),
        .q_ready (q_in_ready)
    );

    mva_fifo #(.WIDTH(ENTRY_W)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (q_in_ready),
        .in_data   (f_entry),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    mva_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_out_valid),
        .q_ready (q_out_ready),
        .q_data  (q_out_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // a front word blocked by a full queue is not dropped
    `MVA_ASSERT_NXT(a_front_keeps, aclk, aresetn, f_valid && !q_in_ready, f_valid)
    // front empties after a push with nothing new behind it
    `MVA_ASSERT_NXT(a_front_drains, aclk, aresetn, f_valid && q_in_ready && !s_valid, !f_valid)
    // the back takes one word and then stays busy with it
    `MVA_ASSERT_NXT(a_back_busy, aclk, aresetn, q_out_valid && q_out_ready, !q_out_ready)
    // a full queue never shows empty
    `MVA_ASSERT_IMP(a_queue_full, aclk, aresetn, !q_in_ready, q_out_valid)

endmodule
